// ===== rtl/eic_pkg.sv =====
// Shared types and constants for the event integrity checker.
package eic_pkg;

    localparam int WORD_W      = 32;
    localparam int EVNUM_W     = 26;
    localparam int INDEX_W     = 16;
    localparam int DW_W        = 11;
    localparam int TOL_W       = 16;
    localparam int TD_W        = TOL_W + DW_W;
    localparam int SQ_W        = 32;
    localparam int SQ_PART_W   = 18;
    localparam int BYTE_PART_W = 10;
    localparam int BSUM_W      = 24;
    localparam int AREA_W      = 16;
    localparam int CMP_W       = SQ_W + 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int NDW_W       = 7;

    localparam logic [INDEX_W-1:0] POS_CLOCK    = 16'd0;
    localparam logic [INDEX_W-1:0] POS_START    = 16'd8;
    localparam logic [INDEX_W-1:0] POS_NUM      = 16'd9;
    localparam logic [INDEX_W-1:0] POS_HIT      = 16'd10;
    localparam logic [INDEX_W-1:0] FIRST_SAMPLE = 16'd11;
    localparam logic [INDEX_W-1:0] INDEX_MAX    = 16'hFFFF;

    localparam logic [CFG_ADDR_W-1:0] REG_DATA_WORDS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEEP_FIRST = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_CHECK = 2'd3;

    localparam logic [NDW_W-1:0] DATA_WORDS_RST = 7'd16;
    localparam logic [TOL_W-1:0] TOLERANCE_RST  = 16'd7680;

    typedef enum logic [2:0] {
        KIND_CLOCK,
        KIND_START,
        KIND_NUM,
        KIND_HIT,
        KIND_SAMPLE,
        KIND_AREA,
        KIND_NONE
    } word_kind_t;

    typedef struct packed {
        logic [DW_W-1:0] data_words;
        logic [TD_W-1:0] tol_times_words;
        logic            keep_first;
        logic            area_on;
    } cfg_t;

    typedef struct packed {
        logic [EVNUM_W-1:0] event_number;
        logic               is_reference;
        logic               clock_header_bad;
        logic               start_header_bad;
        logic               length_bad;
        logic               sequence_bad;
        logic               hitpattern_bad;
    } header_result_t;

    typedef struct packed {
        logic                   last;
        logic [SQ_PART_W-1:0]   sq_part;
        logic [BYTE_PART_W-1:0] byte_part;
        logic                   is_area;
        logic [AREA_W-1:0]      area_val;
        header_result_t         hdr;
    } word_info_t;

    typedef struct packed {
        header_result_t  hdr;
        logic [SQ_W-1:0] square_sum;
        logic            area_bad;
    } event_info_t;

    typedef struct packed {
        header_result_t hdr;
        logic           pulse_changed;
        logic           glitch;
        logic           area_bad;
    } result_t;

endpackage

// ===== rtl/eic_cfg.sv =====
// Configuration registers and the derived tolerance product.
module eic_cfg #(
    parameter int MAX_DATA_WORDS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [eic_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [eic_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output eic_pkg::cfg_t                     cfg
);

    localparam logic [eic_pkg::DW_W-1:0] MAX_WORDS = eic_pkg::DW_W'(MAX_DATA_WORDS);

    logic [eic_pkg::NDW_W-1:0] data_words_reg;
    logic [eic_pkg::TOL_W-1:0] tolerance_reg;
    logic                      keep_first_reg;
    logic                      area_on_reg;
    logic [eic_pkg::TD_W-1:0]  tol_words_reg;
    logic [eic_pkg::TD_W-1:0]  tol_words_next;
    logic [eic_pkg::DW_W-1:0]  eff_words;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_words_reg <= eic_pkg::DATA_WORDS_RST;
            tolerance_reg  <= eic_pkg::TOLERANCE_RST;
            keep_first_reg <= 1'b0;
            area_on_reg    <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                eic_pkg::REG_DATA_WORDS: data_words_reg <= cfg_wdata[eic_pkg::NDW_W-1:0];
                eic_pkg::REG_TOLERANCE:  tolerance_reg  <= cfg_wdata[eic_pkg::TOL_W-1:0];
                eic_pkg::REG_KEEP_FIRST: keep_first_reg <= cfg_wdata[0];
                eic_pkg::REG_AREA_CHECK: area_on_reg    <= cfg_wdata[0];
            endcase
        end
    end

    // Word counts above the store depth are clamped to the depth.
    assign eff_words = (eic_pkg::DW_W'(data_words_reg) > MAX_WORDS) ? MAX_WORDS
                                                                   : eic_pkg::DW_W'(data_words_reg);

    assign tol_words_next = eic_pkg::TD_W'(tolerance_reg) * eic_pkg::TD_W'(eff_words);

    always_ff @(posedge aclk) begin
        tol_words_reg <= tol_words_next;
    end

    assign cfg.data_words      = eff_words;
    assign cfg.tol_times_words = tol_words_reg;
    assign cfg.keep_first      = keep_first_reg;
    assign cfg.area_on         = area_on_reg;

endmodule

// ===== rtl/eic_track.sv =====
// Word position tracking, header checks and the reference pulse store.
module eic_track #(
    parameter int MAX_DATA_WORDS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  eic_pkg::cfg_t                  cfg,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [eic_pkg::WORD_W-1:0]     s_readout_word,
    input  logic                           s_last_word,
    output logic                           info_valid,
    input  logic                           info_ready,
    output eic_pkg::word_info_t            info
);

    localparam int ADDR_W = (MAX_DATA_WORDS > 1) ? $clog2(MAX_DATA_WORDS) : 1;

    logic [eic_pkg::WORD_W-1:0] pulse_mem [MAX_DATA_WORDS];

    logic                        accept;
    logic                        p1_go;
    logic [eic_pkg::INDEX_W-1:0] word_index_reg;
    logic [eic_pkg::INDEX_W-1:0] word_index_next;
    logic [eic_pkg::INDEX_W-1:0] count_next;
    logic [eic_pkg::INDEX_W-1:0] pos_rel;
    eic_pkg::word_kind_t         in_kind;

    logic                        p1_valid_reg;
    logic [eic_pkg::WORD_W-1:0]  p1_word_reg;
    logic                        p1_last_reg;
    eic_pkg::word_kind_t         p1_kind_reg;
    logic [eic_pkg::INDEX_W-1:0] p1_count_reg;
    logic [ADDR_W-1:0]           p1_addr_reg;
    logic [eic_pkg::WORD_W-1:0]  rd_data_reg;
    logic                        mem_we;

    logic [eic_pkg::WORD_W-1:0]  ref_clock_reg;
    logic [eic_pkg::WORD_W-1:0]  ref_start_reg;
    logic [eic_pkg::WORD_W-1:0]  ref_hit_reg;
    logic [eic_pkg::INDEX_W-1:0] ref_count_reg;
    logic [eic_pkg::EVNUM_W-1:0] prev_num_reg;
    logic [eic_pkg::EVNUM_W-1:0] cur_num_reg;
    logic                        have_ref_reg;
    logic                        clock_bad_reg, start_seen_reg, start_bad_reg;
    logic                        num_seen_reg, hit_seen_reg, hit_bad_reg;

    logic [eic_pkg::EVNUM_W-1:0] cur_num_next;
    logic                        clock_bad_next, start_seen_next, start_bad_next;
    logic                        num_seen_next, hit_seen_next, hit_bad_next;
    logic [eic_pkg::EVNUM_W:0]   expect_num;

    logic [7:0]                         b_byte, r_byte, diff;
    logic [15:0]                        diff_w;
    logic [eic_pkg::SQ_PART_W-1:0]      sq_sum;
    logic [eic_pkg::BYTE_PART_W-1:0]    byte_total;

    assign accept     = s_valid && s_ready;
    assign s_ready    = !p1_valid_reg || info_ready;
    assign p1_go      = p1_valid_reg && info_ready;
    assign info_valid = p1_valid_reg;

    // Position of the arriving word decides what it is.
    assign pos_rel    = word_index_reg - eic_pkg::FIRST_SAMPLE;
    assign count_next = (word_index_reg == eic_pkg::INDEX_MAX) ? eic_pkg::INDEX_MAX
                                                               : word_index_reg + 1'b1;
    assign word_index_next = s_last_word ? '0 : count_next;

    always_comb begin
        priority if (word_index_reg == eic_pkg::POS_CLOCK) begin
            in_kind = eic_pkg::KIND_CLOCK;
        end else if (word_index_reg == eic_pkg::POS_START) begin
            in_kind = eic_pkg::KIND_START;
        end else if (word_index_reg == eic_pkg::POS_NUM) begin
            in_kind = eic_pkg::KIND_NUM;
        end else if (word_index_reg == eic_pkg::POS_HIT) begin
            in_kind = eic_pkg::KIND_HIT;
        end else if (word_index_reg >= eic_pkg::FIRST_SAMPLE &&
                     pos_rel < eic_pkg::INDEX_W'(cfg.data_words)) begin
            in_kind = eic_pkg::KIND_SAMPLE;
        end else if (word_index_reg >= eic_pkg::FIRST_SAMPLE &&
                     pos_rel == eic_pkg::INDEX_W'(cfg.data_words)) begin
            in_kind = eic_pkg::KIND_AREA;
        end else begin
            in_kind = eic_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_index_reg <= '0;
            p1_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                word_index_reg <= word_index_next;
            end
            if (s_ready) begin
                p1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_word_reg  <= s_readout_word;
            p1_last_reg  <= s_last_word;
            p1_kind_reg  <= in_kind;
            p1_count_reg <= count_next;
            p1_addr_reg  <= pos_rel[ADDR_W-1:0];
        end
    end

    // Reference pulse store: the entry for a sample word is read when the word
    // is taken, rewritten as it leaves, unless keep_first holds a reference.
    assign mem_we = p1_go && (p1_kind_reg == eic_pkg::KIND_SAMPLE) &&
                    (!have_ref_reg || !cfg.keep_first);

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= pulse_mem[pos_rel[ADDR_W-1:0]];
        end
        if (mem_we) begin
            pulse_mem[p1_addr_reg] <= p1_word_reg;
        end
    end

    // Per-word pulse contributions.
    always_comb begin
        sq_sum     = '0;
        byte_total = '0;
        b_byte     = '0;
        r_byte     = '0;
        diff       = '0;
        diff_w     = '0;
        for (int i = 0; i < 4; i++) begin
            b_byte     = p1_word_reg[8*i +: 8];
            r_byte     = rd_data_reg[8*i +: 8];
            diff       = (b_byte > r_byte) ? b_byte - r_byte : r_byte - b_byte;
            diff_w     = {8'd0, diff};
            sq_sum     = sq_sum + eic_pkg::SQ_PART_W'(diff_w * diff_w);
            byte_total = byte_total + eic_pkg::BYTE_PART_W'(b_byte);
        end
    end

    // Header flags including the word in this stage.
    always_comb begin
        clock_bad_next  = clock_bad_reg;
        start_seen_next = start_seen_reg;
        start_bad_next  = start_bad_reg;
        num_seen_next   = num_seen_reg;
        hit_seen_next   = hit_seen_reg;
        hit_bad_next    = hit_bad_reg;
        cur_num_next    = cur_num_reg;
        unique case (p1_kind_reg)
            eic_pkg::KIND_CLOCK: begin
                clock_bad_next = clock_bad_reg | (have_ref_reg && p1_word_reg != ref_clock_reg);
            end
            eic_pkg::KIND_START: begin
                start_seen_next = 1'b1;
                start_bad_next  = start_bad_reg | (have_ref_reg && p1_word_reg != ref_start_reg);
            end
            eic_pkg::KIND_NUM: begin
                num_seen_next = 1'b1;
                cur_num_next  = p1_word_reg[eic_pkg::EVNUM_W-1:0];
            end
            eic_pkg::KIND_HIT: begin
                hit_seen_next = 1'b1;
                hit_bad_next  = hit_bad_reg | (have_ref_reg && p1_word_reg != ref_hit_reg);
            end
            default: begin
            end
        endcase
    end

    // The expected number is formed one bit wider, so a wrap never matches.
    assign expect_num = {1'b0, prev_num_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_clock_reg  <= '0;
            ref_start_reg  <= '0;
            ref_hit_reg    <= '0;
            ref_count_reg  <= '0;
            prev_num_reg   <= '0;
            cur_num_reg    <= '0;
            have_ref_reg   <= 1'b0;
            clock_bad_reg  <= 1'b0;
            start_seen_reg <= 1'b0;
            start_bad_reg  <= 1'b0;
            num_seen_reg   <= 1'b0;
            hit_seen_reg   <= 1'b0;
            hit_bad_reg    <= 1'b0;
        end else if (p1_go) begin
            if (!have_ref_reg) begin
                if (p1_kind_reg == eic_pkg::KIND_CLOCK) begin
                    ref_clock_reg <= p1_word_reg;
                end
                if (p1_kind_reg == eic_pkg::KIND_START) begin
                    ref_start_reg <= p1_word_reg;
                end
                if (p1_kind_reg == eic_pkg::KIND_HIT) begin
                    ref_hit_reg <= p1_word_reg;
                end
            end
            if (p1_last_reg) begin
                if (!have_ref_reg) begin
                    ref_count_reg <= p1_count_reg;
                    have_ref_reg  <= 1'b1;
                end
                prev_num_reg   <= cur_num_next;
                cur_num_reg    <= '0;
                clock_bad_reg  <= 1'b0;
                start_seen_reg <= 1'b0;
                start_bad_reg  <= 1'b0;
                num_seen_reg   <= 1'b0;
                hit_seen_reg   <= 1'b0;
                hit_bad_reg    <= 1'b0;
            end else begin
                cur_num_reg    <= cur_num_next;
                clock_bad_reg  <= clock_bad_next;
                start_seen_reg <= start_seen_next;
                start_bad_reg  <= start_bad_next;
                num_seen_reg   <= num_seen_next;
                hit_seen_reg   <= hit_seen_next;
                hit_bad_reg    <= hit_bad_next;
            end
        end
    end

    always_comb begin
        info.last      = p1_last_reg;
        info.sq_part   = (p1_kind_reg == eic_pkg::KIND_SAMPLE && have_ref_reg) ? sq_sum : '0;
        info.byte_part = (p1_kind_reg == eic_pkg::KIND_SAMPLE) ? byte_total : '0;
        info.is_area   = (p1_kind_reg == eic_pkg::KIND_AREA);
        info.area_val  = p1_word_reg[eic_pkg::AREA_W-1:0];
        info.hdr.event_number     = cur_num_next;
        info.hdr.is_reference     = !have_ref_reg;
        info.hdr.clock_header_bad = have_ref_reg && clock_bad_next;
        info.hdr.start_header_bad = have_ref_reg && (!start_seen_next || start_bad_next);
        info.hdr.length_bad       = have_ref_reg && (p1_count_reg != ref_count_reg);
        info.hdr.sequence_bad     = have_ref_reg &&
                                    (!num_seen_next || {1'b0, cur_num_next} != expect_num);
        info.hdr.hitpattern_bad   = have_ref_reg && (!hit_seen_next || hit_bad_next);
    end

endmodule

// ===== rtl/eic_accum.sv =====
// Per-event square and byte sums and the area word check.
module eic_accum (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  area_on,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  eic_pkg::word_info_t   in_info,
    output logic                  ev_valid,
    input  logic                  ev_ready,
    output eic_pkg::event_info_t  ev
);

    logic                       p2_valid_reg;
    eic_pkg::word_info_t        p2_info_reg;
    logic                       p2_go;
    logic [eic_pkg::SQ_W-1:0]   sq_sum_reg, sq_sum_next;
    logic [eic_pkg::BSUM_W-1:0] byte_sum_reg, byte_sum_next;
    logic                       area_seen_reg, area_seen_next;
    logic                       area_bad_reg, area_bad_next;

    // Words that do not close an event never wait for the next stage.
    assign p2_go    = p2_valid_reg && (!p2_info_reg.last || ev_ready);
    assign in_ready = !p2_valid_reg || p2_go;
    assign ev_valid = p2_valid_reg && p2_info_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (in_ready) begin
            p2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            p2_info_reg <= in_info;
        end
    end

    // The area word follows every sample word, so the byte sum is complete here.
    assign sq_sum_next    = sq_sum_reg + eic_pkg::SQ_W'(p2_info_reg.sq_part);
    assign byte_sum_next  = byte_sum_reg + eic_pkg::BSUM_W'(p2_info_reg.byte_part);
    assign area_seen_next = area_seen_reg | p2_info_reg.is_area;
    assign area_bad_next  = area_bad_reg |
                            (p2_info_reg.is_area &&
                             byte_sum_reg != eic_pkg::BSUM_W'(p2_info_reg.area_val));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_sum_reg    <= '0;
            byte_sum_reg  <= '0;
            area_seen_reg <= 1'b0;
            area_bad_reg  <= 1'b0;
        end else if (p2_go) begin
            if (p2_info_reg.last) begin
                sq_sum_reg    <= '0;
                byte_sum_reg  <= '0;
                area_seen_reg <= 1'b0;
                area_bad_reg  <= 1'b0;
            end else begin
                sq_sum_reg    <= sq_sum_next;
                byte_sum_reg  <= byte_sum_next;
                area_seen_reg <= area_seen_next;
                area_bad_reg  <= area_bad_next;
            end
        end
    end

    assign ev.hdr        = p2_info_reg.hdr;
    assign ev.square_sum = sq_sum_next;
    assign ev.area_bad   = !p2_info_reg.hdr.is_reference && area_on &&
                           (!area_seen_next || area_bad_next);

endmodule

// ===== rtl/eic_judge.sv =====
// Pulse tolerance compare, glitch tracking and the result register.
module eic_judge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [eic_pkg::TD_W-1:0]      tol_times_words,
    input  logic                          ev_valid,
    output logic                          ev_ready,
    input  eic_pkg::event_info_t          ev,
    output logic                          m_valid,
    input  logic                          m_ready,
    output eic_pkg::result_t              result
);

    logic                        p3_valid_reg;
    eic_pkg::event_info_t        p3_event_reg;
    logic                        out_valid_reg;
    eic_pkg::result_t            result_reg, result_next;
    logic                        prev_changed_reg;
    logic                        out_free;
    logic                        p3_go;
    logic [eic_pkg::CMP_W-1:0]   lhs, rhs, td_wide;
    logic                        changed;

    assign out_free = !out_valid_reg || m_ready;
    assign ev_ready = !p3_valid_reg || out_free;
    assign p3_go    = p3_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (ev_ready && ev_valid) begin
            p3_event_reg <= ev;
        end
    end

    // Mean square over nine against an 8.8 tolerance, cross-multiplied:
    // S * 256 > tol * 36 * D.
    assign lhs     = eic_pkg::CMP_W'({p3_event_reg.square_sum, 8'h00});
    assign td_wide = eic_pkg::CMP_W'(tol_times_words);
    assign rhs     = (td_wide << 5) + (td_wide << 2);
    assign changed = !p3_event_reg.hdr.is_reference && (lhs > rhs);

    always_comb begin
        result_next.hdr           = p3_event_reg.hdr;
        result_next.pulse_changed = changed;
        result_next.glitch        = changed && prev_changed_reg;
        result_next.area_bad      = p3_event_reg.area_bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            prev_changed_reg <= 1'b0;
        end else begin
            if (ev_ready) begin
                p3_valid_reg <= ev_valid;
            end
            if (out_free) begin
                out_valid_reg <= p3_valid_reg;
            end
            if (p3_go) begin
                prev_changed_reg <= changed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p3_go) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = result_reg;

endmodule

// ===== rtl/event_integrity_checker.sv =====
// A result reaches m_valid once its event's last word has passed the track, accumulate and judge registers.
// Throughput: one readout word per cycle; results never stall input unless the output is full.
// The pulse store has one read and one write port; the read is taken as the word is accepted.
// Reset (synchronous, active low) restores the register defaults and drops the reference.
// The reference pulse store is not cleared; the first event after reset refills it.
module event_integrity_checker #(
    parameter int MAX_DATA_WORDS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [eic_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  logic [eic_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [eic_pkg::WORD_W-1:0]      s_readout_word,
    input  logic                            s_last_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [eic_pkg::EVNUM_W-1:0]     m_event_number,
    output logic                            m_is_reference,
    output logic                            m_clock_header_bad,
    output logic                            m_start_header_bad,
    output logic                            m_length_bad,
    output logic                            m_sequence_bad,
    output logic                            m_hitpattern_bad,
    output logic                            m_pulse_changed,
    output logic                            m_glitch,
    output logic                            m_area_bad
);

    eic_pkg::cfg_t        cfg;
    eic_pkg::word_info_t  info;
    eic_pkg::event_info_t ev;
    eic_pkg::result_t     result;
    logic                 info_valid, info_ready;
    logic                 ev_valid, ev_ready;

    eic_cfg #(
        .MAX_DATA_WORDS (MAX_DATA_WORDS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    eic_track #(
        .MAX_DATA_WORDS (MAX_DATA_WORDS)
    ) u_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_readout_word (s_readout_word),
        .s_last_word    (s_last_word),
        .info_valid     (info_valid),
        .info_ready     (info_ready),
        .info           (info)
    );

    eic_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .area_on  (cfg.area_on),
        .in_valid (info_valid),
        .in_ready (info_ready),
        .in_info  (info),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev)
    );

    eic_judge u_judge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tol_times_words (cfg.tol_times_words),
        .ev_valid        (ev_valid),
        .ev_ready        (ev_ready),
        .ev              (ev),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .result          (result)
    );

    assign m_event_number     = result.hdr.event_number;
    assign m_is_reference     = result.hdr.is_reference;
    assign m_clock_header_bad = result.hdr.clock_header_bad;
    assign m_start_header_bad = result.hdr.start_header_bad;
    assign m_length_bad       = result.hdr.length_bad;
    assign m_sequence_bad     = result.hdr.sequence_bad;
    assign m_hitpattern_bad   = result.hdr.hitpattern_bad;
    assign m_pulse_changed    = result.pulse_changed;
    assign m_glitch           = result.glitch;
    assign m_area_bad         = result.area_bad;

endmodule

// ===== rtl/eic_checker.sv =====
// Port-level assertions for the event integrity checker and their bind.
module eic_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [eic_pkg::EVNUM_W-1:0]     m_event_number,
    input logic                            m_is_reference,
    input logic                            m_clock_header_bad,
    input logic                            m_start_header_bad,
    input logic                            m_length_bad,
    input logic                            m_sequence_bad,
    input logic                            m_hitpattern_bad,
    input logic                            m_pulse_changed,
    input logic                            m_glitch,
    input logic                            m_area_bad
);

    // A waiting result holds still until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_number) &&
            $stable(m_pulse_changed) && $stable(m_area_bad) && $stable(m_is_reference))
        else $error("result changed while stalled");

    // The reference event is never checked.
    a_ref_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_reference |-> !m_clock_header_bad && !m_start_header_bad &&
            !m_length_bad && !m_sequence_bad && !m_hitpattern_bad &&
            !m_pulse_changed && !m_glitch && !m_area_bad)
        else $error("reference event carries a check flag");

    // A glitch needs a pulse change on the same event.
    a_glitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_glitch |-> m_pulse_changed)
        else $error("glitch without pulse change");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind event_integrity_checker eic_checker u_eic_checker (.*);
